// File: hw/rtl/assert_macros.svh
// Assertion helper macros for the timing spread block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gts: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gts: next-cycle check failed");

`endif

// File: hw/rtl/gts_pkg.sv
// Shared types and fixed constants for the timing spread block.
// No dependencies; imported by gated_timing_spread and its testbench.
`timescale 1ns / 1ps

package gts_pkg;

	localparam int TIME_W   = 16;
	localparam int CHARGE_W = 16;
	localparam int SPREAD_W = 15;

	localparam logic [CHARGE_W-1:0] THRESH_RESET = 16'd26;

	typedef struct packed {
		logic                     side;
		logic signed [TIME_W-1:0] sample_time;
		logic                     time_valid;
		logic [CHARGE_W-1:0]      sample_charge;
		logic                     event_last;
	} hit_t;

	typedef struct packed {
		logic [SPREAD_W-1:0] avg_spread;
		logic [SPREAD_W-1:0] north_spread;
		logic [SPREAD_W-1:0] south_spread;
	} spread_t;

endpackage

// File: hw/rtl/gated_timing_spread.sv
// Top level of the gated timing spread block: hit accumulation and spread sequencer.
// Depends on gts_pkg for beat types and on assert_macros.svh for its checks.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// The block takes one detector hit per input beat and keeps, for each side, the count,
// sum and sum of squares of hits whose charge is above thresh_q and whose time
// is valid (at most CHANNELS_PER_SIDE per side and event). The accept cycle latches the
// hit with its time squared, and ST_ACC then adds it into the side's sums. A hit with
// event_last set then starts the spread sequencer, which runs every step through one
// shared adder/subtractor. For each side with two or more kept hits it takes |sum|,
// forms n*sumsq and sum^2 by shift-add, takes the difference, then the integer square
// root and the division by n; a side with fewer hits gets a spread of zero. ST_AVG
// then forms the combined spread and clears the sums, and ST_HOLD loads the output
// register. With the default of 64 channels, CNT_W = 7, MAG_W = 22 and R_W = 22. After
// a last hit the input is not ready again until the sequencer is back in ST_IDLE, and
// ST_HOLD stays while the output register is full and not taken. The result waits in
// the output register, so the next event's hits are accepted while it is still pending;
// a second result only waits if the first one has not been taken by then.
module gated_timing_spread
	import gts_pkg::*;
#(
	parameter int CHANNELS_PER_SIDE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CHARGE_W-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  hit_t                in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spread_t             out_data
);

	// Widths that follow from the channel count.
	localparam int LOG_C  = $clog2(CHANNELS_PER_SIDE);
	localparam int CNT_W  = $clog2(CHANNELS_PER_SIDE + 1);
	localparam int SUM_W  = LOG_C + TIME_W + 1;
	localparam int MAG_W  = SUM_W - 1;
	localparam int SQ_W   = LOG_C + 2 * TIME_W - 1;
	localparam int PROD_W = CNT_W + SQ_W;
	localparam int R_W    = (PROD_W + 1) / 2;
	localparam int V_W    = 2 * R_W;
	localparam int ALU_W  = V_W + 1;
	localparam int STEP_W = $clog2(V_W);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_MAG   = 4'd2;
	localparam logic [3:0] ST_MUL_P = 4'd3;
	localparam logic [3:0] ST_MUL_S = 4'd4;
	localparam logic [3:0] ST_DIFF  = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_AVG   = 4'd8;
	localparam logic [3:0] ST_HOLD  = 4'd9;

	logic [3:0]             state_q;
	logic [CHARGE_W-1:0]    thresh_q;

	// Per-side accumulators.
	logic [CNT_W-1:0]        cnt_n_q, cnt_s_q;
	logic signed [SUM_W-1:0] sum_n_q, sum_s_q;
	logic [SQ_W-1:0]         sumsq_n_q, sumsq_s_q;

	// Latched hit.
	logic                    hit_side_q;
	logic                    hit_keep_q;
	logic                    hit_last_q;
	logic signed [TIME_W-1:0] hit_time_q;
	logic [2*TIME_W-1:0]     hit_sq_q;

	// Sequencer datapath.
	logic                    side_sel_q;
	logic [STEP_W-1:0]       step_q;
	logic [ALU_W-1:0]        acc_q;
	logic [PROD_W-1:0]       prod_q;
	logic [MAG_W-1:0]        mag_q;
	logic [V_W-1:0]          sh_q;
	logic [R_W+1:0]          rem_q;
	logic [R_W-1:0]          root_q;
	logic [SPREAD_W-1:0]     ns_q, ss_q, avg_q;

	logic                    out_valid_q;
	spread_t                 out_q;

	// Shared adder/subtractor.
	logic [ALU_W-1:0]        alu_a, alu_b, alu_y;
	logic                    alu_sub;
	logic                    alu_neg;

	// Selected side for the sequencer and incoming hit decode.
	logic [CNT_W-1:0]        cnt_sel;
	logic signed [SUM_W-1:0] sum_sel;
	logic [SQ_W-1:0]         sumsq_sel;
	logic [CNT_W-1:0]        cnt_hit;
	logic [TIME_W-1:0]       hit_mag;
	logic                    hit_keep;
	logic                    accept;
	logic                    out_load;
	logic [R_W+1:0]          rem_sh;
	logic [R_W+1:0]          trial;
	logic [CNT_W:0]          drem_sh;
	logic [R_W-1:0]          root_nx;
	logic                    last_step;

	// Terms for the checks at the end of the module.
	logic                    cnt_in_range;
	logic                    sums_clear;
	logic                    hold_stall;

	assign cnt_sel   = side_sel_q ? cnt_s_q : cnt_n_q;
	assign sum_sel   = side_sel_q ? sum_s_q : sum_n_q;
	assign sumsq_sel = side_sel_q ? sumsq_s_q : sumsq_n_q;

	assign accept   = in_valid && in_ready;
	assign cnt_hit  = in_data.side ? cnt_s_q : cnt_n_q;
	assign hit_mag  = in_data.sample_time[TIME_W-1] ? (~in_data.sample_time + 1'b1)
		: in_data.sample_time;
	assign hit_keep = in_data.time_valid && (in_data.sample_charge > thresh_q)
		&& (cnt_hit < CNT_W'(CHANNELS_PER_SIDE));

	// Square-root and division operands; a square-root step brings down two bits.
	assign rem_sh    = {rem_q[R_W-1:0], sh_q[V_W-1:V_W-2]};
	assign trial     = {root_q, 2'b01};
	assign drem_sh   = {rem_q[CNT_W-1:0], sh_q[V_W-1]};
	assign last_step = (step_q == '0);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MAG: begin
				if (sum_sel[SUM_W-1]) begin
					alu_b   = ALU_W'($unsigned(sum_sel));
					alu_sub = 1'b1;
				end else begin
					alu_a = ALU_W'($unsigned(sum_sel));
				end
			end
			ST_MUL_P: begin
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = sh_q[V_W-1] ? ALU_W'(sumsq_sel) : '0;
			end
			ST_MUL_S: begin
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = sh_q[V_W-1] ? ALU_W'(mag_q) : '0;
			end
			ST_DIFF: begin
				alu_a   = ALU_W'(prod_q);
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			ST_SQRT: begin
				alu_a   = ALU_W'(rem_sh);
				alu_b   = ALU_W'(trial);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = ALU_W'(drem_sh);
				alu_b   = ALU_W'(cnt_sel);
				alu_sub = 1'b1;
			end
			ST_AVG: begin
				alu_a = ALU_W'(ns_q);
				alu_b = ALU_W'(ss_q);
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_y[ALU_W-1];

	// Next root or quotient: shift in one result bit.
	assign root_nx = {root_q[R_W-2:0], ~alu_neg};

	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_data;
		end
	end

	// Control state and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_sel_q  <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_n_q     <= '0;
			cnt_s_q     <= '0;
			sum_n_q     <= '0;
			sum_s_q     <= '0;
			sumsq_n_q   <= '0;
			sumsq_s_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (hit_keep_q) begin
						if (hit_side_q) begin
							cnt_s_q   <= cnt_s_q + 1'b1;
							sum_s_q   <= sum_s_q + SUM_W'(hit_time_q);
							sumsq_s_q <= sumsq_s_q + SQ_W'(hit_sq_q);
						end else begin
							cnt_n_q   <= cnt_n_q + 1'b1;
							sum_n_q   <= sum_n_q + SUM_W'(hit_time_q);
							sumsq_n_q <= sumsq_n_q + SQ_W'(hit_sq_q);
						end
					end
					side_sel_q <= 1'b0;
					state_q    <= hit_last_q ? ST_MAG : ST_IDLE;
				end
				ST_MAG: begin
					if (cnt_sel <= CNT_W'(1)) begin
						side_sel_q <= 1'b1;
						state_q    <= side_sel_q ? ST_AVG : ST_MAG;
					end else begin
						step_q  <= STEP_W'(CNT_W - 1);
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					if (last_step) begin
						step_q  <= STEP_W'(MAG_W - 1);
						state_q <= ST_MUL_S;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_MUL_S: begin
					if (last_step) begin
						state_q <= ST_DIFF;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DIFF: begin
					step_q  <= STEP_W'(R_W - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					step_q <= last_step ? STEP_W'(R_W - 1) : step_q - 1'b1;
					if (last_step) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_step) begin
						side_sel_q <= 1'b1;
						state_q    <= side_sel_q ? ST_AVG : ST_MAG;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_AVG: begin
					cnt_n_q   <= '0;
					cnt_s_q   <= '0;
					sum_n_q   <= '0;
					sum_s_q   <= '0;
					sumsq_n_q <= '0;
					sumsq_s_q <= '0;
					state_q   <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the hit latch and the sequencer datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_side_q <= in_data.side;
			hit_keep_q <= hit_keep;
			hit_last_q <= in_data.event_last;
			hit_time_q <= in_data.sample_time;
			hit_sq_q   <= {{TIME_W{1'b0}}, hit_mag} * {{TIME_W{1'b0}}, hit_mag};
		end

		case (state_q)
			ST_MAG: begin
				mag_q <= alu_y[MAG_W-1:0];
				acc_q <= '0;
				sh_q  <= {cnt_sel, {(V_W - CNT_W){1'b0}}};
				if (cnt_sel <= CNT_W'(1)) begin
					if (side_sel_q) begin
						ss_q <= '0;
					end else begin
						ns_q <= '0;
					end
				end
			end
			ST_MUL_P: begin
				if (last_step) begin
					prod_q <= alu_y[PROD_W-1:0];
					acc_q  <= '0;
					sh_q   <= {mag_q, {(V_W - MAG_W){1'b0}}};
				end else begin
					acc_q <= alu_y;
					sh_q  <= {sh_q[V_W-2:0], 1'b0};
				end
			end
			ST_MUL_S: begin
				acc_q <= alu_y;
				sh_q  <= {sh_q[V_W-2:0], 1'b0};
			end
			ST_DIFF: begin
				// n*sumsq never falls below sum^2, but clamp the difference anyway.
				sh_q   <= alu_neg ? '0 : alu_y[V_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				if (last_step) begin
					rem_q  <= '0;
					root_q <= '0;
					sh_q   <= {root_nx, {(V_W - R_W){1'b0}}};
				end else begin
					rem_q  <= alu_neg ? rem_sh : alu_y[R_W+1:0];
					root_q <= root_nx;
					sh_q   <= {sh_q[V_W-3:0], 2'b00};
				end
			end
			ST_DIV: begin
				rem_q  <= alu_neg ? (R_W + 2)'(drem_sh) : alu_y[R_W+1:0];
				root_q <= root_nx;
				sh_q   <= {sh_q[V_W-2:0], 1'b0};
				if (last_step) begin
					if (side_sel_q) begin
						ss_q <= root_nx[SPREAD_W-1:0];
					end else begin
						ns_q <= root_nx[SPREAD_W-1:0];
					end
				end
			end
			ST_AVG: begin
				// A spread of zero counts as no spread for the combined value.
				if ((ns_q != '0) && (ss_q != '0)) begin
					avg_q <= alu_y[SPREAD_W:1];
				end else if (ns_q != '0) begin
					avg_q <= ns_q;
				end else begin
					avg_q <= ss_q;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_q.avg_spread   <= avg_q;
			out_q.north_spread <= ns_q;
			out_q.south_spread <= ss_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_in_range = (cnt_n_q <= CNT_W'(CHANNELS_PER_SIDE))
		&& (cnt_s_q <= CNT_W'(CHANNELS_PER_SIDE));
	assign sums_clear   = (cnt_n_q == '0) && (cnt_s_q == '0) && (sum_n_q == '0)
		&& (sum_s_q == '0) && (sumsq_n_q == '0) && (sumsq_s_q == '0);
	assign hold_stall   = (state_q == ST_HOLD) && out_valid_q && !out_ready;

	`GTS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_in_range)
	`GTS_ASSERT_NXT(a_accept_acc, clk, arst_n, accept, state_q == ST_ACC)
	`GTS_ASSERT_NXT(a_clear_after, clk, arst_n, state_q == ST_AVG, sums_clear)
	`GTS_ASSERT_NXT(a_hold_wait, clk, arst_n, hold_stall, (state_q == ST_HOLD) && out_valid_q)

endmodule

// File: tb/tb_gated_timing_spread.sv
// Self-checking testbench for gated_timing_spread: random and directed hit beats in,
// per-event spread results checked against an in-bench model of the accumulators.
// Depends on gts_pkg for the beat types and on the gated_timing_spread RTL.
`timescale 1ns / 1ps

module tb_gated_timing_spread;
	import gts_pkg::*;

	// The block caps each side at this many kept hits per event.
	localparam int HITS_PER_SIDE = 64;
	// A last hit keeps the sequencer busy until it has formed and loaded its result; allow
	// some margin before touching the threshold or ending the run.
	localparam int SETTLE_CYCLES = 200;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CHARGE_W-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	hit_t                in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	spread_t             out_data;

	gated_timing_spread #(
		.CHANNELS_PER_SIDE(HITS_PER_SIDE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Hits waiting to be offered, and spread results the model says are on their way.
	hit_t    hit_pending [$];
	spread_t spread_due  [$];

	// Model copy of the threshold register and of the two sides' accumulators.
	logic [CHARGE_W-1:0] thresh_model = THRESH_RESET;
	int unsigned         side_n   [2] = '{0, 0};
	longint              side_sum [2] = '{0, 0};
	longint unsigned     side_sq  [2] = '{0, 0};

	int  mismatches    = 0;
	int  beats_seen    = 0;
	bit  hit_took      = 1'b0;
	int  rx_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Safety net: ends a run that hangs and reports it as a mismatch.
	initial begin
		#4_000_000;
		$display("gated_timing_spread: mismatch");
		$finish;
	end

	// Appends one hit to the tail of the driver's queue.
	function automatic void queue_hit(hit_t h);
		hit_pending.insert(hit_pending.size(), h);
	endfunction

	// Largest r with r*r <= v, one result bit at a time. The difference that feeds
	// it stays below 2^43, so the root fits in 22 bits.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 23; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v) r = trial;
		end
		return r;
	endfunction

	// Population standard deviation of one side: floor(isqrt(n*sumsq - sum^2) / n).
	// Fewer than two kept hits means no spread at all.
	function automatic logic [SPREAD_W-1:0] side_deviation(int s);
		longint unsigned n;
		longint unsigned mag;
		longint unsigned prod;
		longint unsigned sq;
		if (side_n[s] < 2) return '0;
		n    = side_n[s];
		mag  = (side_sum[s] < 0) ? -side_sum[s] : side_sum[s];
		prod = n * side_sq[s];
		sq   = mag * mag;
		return SPREAD_W'(floor_root((prod > sq) ? prod - sq : 64'd0) / n);
	endfunction

	// Applies one accepted hit to the model. A hit is kept only when its time is
	// valid, its charge is strictly above the threshold and its side still has room.
	// The last hit of an event is counted first, then the result is formed and every
	// accumulator is cleared, whether or not that last hit itself was kept.
	function automatic void absorb_hit(hit_t h);
		longint          t;
		spread_t         r;
		logic [SPREAD_W-1:0] ns;
		logic [SPREAD_W-1:0] ss;
		t = longint'($signed(h.sample_time));
		if (h.time_valid && h.sample_charge > thresh_model
				&& side_n[h.side] < HITS_PER_SIDE) begin
			side_n[h.side]++;
			side_sum[h.side] += t;
			side_sq[h.side]  += longint'(t * t);
		end
		if (h.event_last) begin
			ns = side_deviation(0);
			ss = side_deviation(1);
			r.north_spread = ns;
			r.south_spread = ss;
			// A side whose spread came out as exactly zero does not pull the average down.
			if (ns != 0 && ss != 0) r.avg_spread = SPREAD_W'(({1'b0, ns} + {1'b0, ss}) >> 1);
			else if (ns != 0) r.avg_spread = ns;
			else r.avg_spread = ss;
			spread_due.insert(spread_due.size(), r);
			for (int s = 0; s < 2; s++) begin
				side_n[s]   = 0;
				side_sum[s] = 0;
				side_sq[s]  = 0;
			end
		end
	endfunction

	task automatic note_mismatch(string what, logic [SPREAD_W-1:0] got,
			logic [SPREAD_W-1:0] want);
		$display("%0t ns: result beat %0d %s: got %0d, model %0d",
			$time, beats_seen, what, got, want);
		mismatches++;
	endtask

	// Input side of the model: every hit beat that crosses the handshake is absorbed
	// here, and the driver learns from hit_took that it may move on.
	always @(posedge clk) begin
		hit_took = 1'b0;
		if (arst_n && in_valid && in_ready) begin
			hit_took = 1'b1;
			absorb_hit(in_data);
		end
	end

	// Result checker: each accepted result beat is held against the oldest prediction.
	always @(posedge clk) begin
		spread_t want;
		if (arst_n && out_valid && out_ready) begin
			if (spread_due.size() == 0) begin
				note_mismatch("arrived with nothing pending", out_data.avg_spread, '0);
			end else begin
				want = spread_due.pop_front();
				if (out_data.avg_spread !== want.avg_spread)
					note_mismatch("avg_spread", out_data.avg_spread, want.avg_spread);
				if (out_data.north_spread !== want.north_spread)
					note_mismatch("north_spread", out_data.north_spread, want.north_spread);
				if (out_data.south_spread !== want.south_spread)
					note_mismatch("south_spread", out_data.south_spread, want.south_spread);
			end
			beats_seen++;
		end
	end

	// Hit driver. It offers beats in bursts of random length separated by random gaps,
	// and now and then a long burst with no gap at all. A beat that is on offer is held
	// unchanged until the handshake takes it.
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !hit_took) begin
			// Still waiting for the block to take the current beat.
		end else if (hit_pending.size() == 0) begin
			in_valid <= 1'b0;
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else begin
			in_data  <= hit_pending.pop_front();
			in_valid <= 1'b1;
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 16);
				gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			end
		end
	end

	// Result receiver. It switches among a few stall styles of random duration. A long
	// hold-off requested by the stimulus is counted down here and overrides the style.
	rx_style_e rx_style     = RX_OPEN;
	int        rx_style_left = 0;
	int        rx_tick      = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_cycles > 0) begin
			out_ready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			if (rx_style_left == 0) begin
				rx_style      = rx_style_e'($urandom_range(0, 3));
				rx_style_left = $urandom_range(20, 400);
			end
			rx_style_left--;
			rx_tick++;
			case (rx_style)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
				default:   out_ready <= ((rx_tick % 7) < 3);
			endcase
		end
	end

	function automatic hit_t mk_hit(bit s, int t, bit v, int c, bit l);
		hit_t h;
		h.side          = s;
		h.sample_time   = TIME_W'(t);
		h.time_valid    = v;
		h.sample_charge = CHARGE_W'(c);
		h.event_last    = l;
		return h;
	endfunction

	// Waits until the driver has nothing left, the block has returned every predicted
	// result, and the pipeline has had time to finish any hit that gives no result.
	task automatic settle();
		while (hit_pending.size() != 0 || in_valid || spread_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The threshold is only changed with the block idle, so the model can switch over
	// right after the write edge.
	task automatic set_threshold(logic [CHARGE_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		thresh_model = v;
	endtask

	// Queues well-formed events with random content until the budget of beats is used.
	// Events are mostly small; some load one side past the per-side cap. Times are
	// either fully random, all equal (zero spread), or clustered around a random
	// center with a random width. Charges straddle the threshold. A few events are cut
	// short with no last hit, and the odd stray beat with random fields slips in.
	task automatic queue_events(int budget, logic [CHARGE_W-1:0] thr);
		int                  per_side [2];
		int                  left;
		int                  pick;
		int                  tval;
		int                  w;
		int                  style;
		bit                  cut_short;
		logic signed [TIME_W-1:0] centre;
		logic [CHARGE_W-1:0] chg;
		hit_t                h;
		while (budget > 0) begin
			if ($urandom_range(0, 19) == 0) begin
				h = $bits(hit_t)'({$urandom, $urandom});
				queue_hit(h);
				budget--;
			end
			per_side[0] = $urandom_range(0, 10);
			per_side[1] = $urandom_range(0, 10);
			if ($urandom_range(0, 14) == 0)
				per_side[$urandom_range(0, 1)] = $urandom_range(66, 90);
			if (per_side[0] + per_side[1] == 0) per_side[$urandom_range(0, 1)] = 1;
			style     = $urandom_range(0, 5);
			centre    = TIME_W'($urandom);
			w         = 1 << $urandom_range(0, 14);
			cut_short = ($urandom_range(0, 19) == 0);
			left      = per_side[0] + per_side[1];
			while (left > 0) begin
				pick = (int'($urandom_range(1, left)) <= per_side[1]) ? 1 : 0;
				per_side[pick]--;
				left--;
				h.side = pick[0];
				case (style)
					0: h.sample_time = TIME_W'($urandom);
					1: h.sample_time = centre;
					default: begin
						tval = int'(centre) + int'($urandom_range(0, 2 * w)) - w;
						h.sample_time = TIME_W'(tval);
					end
				endcase
				h.time_valid = ($urandom_range(0, 11) != 0);
				case ($urandom_range(0, 9))
					0: chg = thr;
					1: chg = CHARGE_W'($urandom);
					2: chg = '1;
					3: chg = '0;
					default: chg = (thr == '1) ? thr
						: CHARGE_W'($urandom_range(int'(thr) + 1, 65535));
				endcase
				h.sample_charge = chg;
				h.event_last    = (left == 0) && !cut_short;
				queue_hit(h);
				budget--;
			end
		end
	endtask

	initial begin
		logic [CHARGE_W-1:0] thr;
		int                  guard;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed events at the reset threshold of 26.
		// Widest possible north spread, a zero-spread south side, a hit with charge
		// equal to the threshold, a hit with an invalid time, and a dropped last hit.
		queue_hit(mk_hit(0, -32768, 1, 65535, 0));
		queue_hit(mk_hit(0,  32767, 1,    27, 0));
		queue_hit(mk_hit(0,    100, 1,    26, 0));
		queue_hit(mk_hit(1,      0, 1,  1000, 0));
		queue_hit(mk_hit(1,      0, 1,   200, 0));
		queue_hit(mk_hit(1,   5000, 0, 65535, 0));
		queue_hit(mk_hit(1,      0, 1,     0, 1));
		// One kept hit per side gives no spread anywhere.
		queue_hit(mk_hit(0,   1234, 1,   500, 0));
		queue_hit(mk_hit(1,     -7, 1,   500, 1));
		// An event made only of a dropped last hit.
		queue_hit(mk_hit(0,      0, 0,     0, 1));
		// Both sides with a spread, so the average is the floored mean.
		queue_hit(mk_hit(0,     10, 1,   300, 0));
		queue_hit(mk_hit(0,     20, 1,   300, 0));
		queue_hit(mk_hit(0,     30, 1,   300, 0));
		queue_hit(mk_hit(1,   -100, 1,   300, 0));
		queue_hit(mk_hit(1,    100, 1,   300, 0));
		queue_hit(mk_hit(1,      0, 1,   300, 1));
		// All-ones and sign-edge times with full charge on both sides.
		queue_hit(mk_hit(1,     -1, 1, 65535, 0));
		queue_hit(mk_hit(1, -32768, 1, 65535, 0));
		queue_hit(mk_hit(0,  32767, 1, 65535, 0));
		queue_hit(mk_hit(0,     -1, 1, 65535, 1));

		// Lowest threshold: only a charge of zero fails the cut.
		set_threshold('0);
		queue_events(350, '0);

		// A moderate threshold. The receiver holds off for a long stretch while the
		// sender keeps offering, so the output register and then the input back up.
		thr = CHARGE_W'($urandom_range(1, 3000));
		set_threshold(thr);
		queue_events(500, thr);
		rx_hold_cycles = 3000;

		// Highest threshold: no hit can be kept, every result is all zero.
		set_threshold('1);
		queue_events(60, '1);

		// A higher threshold, with the sender pausing halfway until every result is in.
		thr = CHARGE_W'($urandom_range(30, 20000));
		set_threshold(thr);
		queue_events(250, thr);
		settle();
		queue_events(250, thr);

		guard = 0;
		while ((hit_pending.size() != 0 || in_valid || spread_due.size() != 0)
				&& guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (spread_due.size() != 0) begin
			note_mismatch("never arrived", '0, spread_due[0].avg_spread);
			void'(spread_due.pop_front());
		end

		if (mismatches == 0) begin
			$display("gated_timing_spread: match");
		end else begin
			$display("gated_timing_spread: mismatch");
		end
		$finish;
	end

endmodule
